// ===== src/ctrv_pkg.sv =====
// ============================================================================
// ctrv_pkg
// Shared constants, types and arithmetic helpers for the CTRV process model.
// ============================================================================
package ctrv_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int Q30_SHIFT    = 30 - FRAC_BITS;

    // Pipeline depths of the sine/cosine unit and the divider
    localparam int SC_LAT   = CORDIC_STEPS + 4;
    localparam int DIV_BITS = 64;
    localparam int DIV_LAT  = DIV_BITS + 1;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_PREV_TIME  = 3'd0,
        REG_CTRL_X     = 3'd1,
        REG_CTRL_Y     = 3'd2,
        REG_CTRL_SPEED = 3'd3,
        REG_CTRL_HEAD  = 3'd4,
        REG_CTRL_TURN  = 3'd5
    } t_reg_idx;

    localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q    =
        (TWO_PI_Q30 + (36'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;

    // Reciprocal of 2*pi for the angle reduction
    localparam int                 RED_SHIFT    = 34;
    localparam logic signed [35:0] TWO_PI_RECIP = (36'sd1 <<< RED_SHIFT) / TWO_PI_Q;

    function automatic logic signed [35:0] atan_q30(input int i);
        logic signed [35:0] t;
        case (i)
            0: t = 36'sh3243F6A8;  1: t = 36'sh1DAC6705;  2: t = 36'sh0FADBAFC;
            3: t = 36'sh07F56EA6;  4: t = 36'sh03FEAB76;  5: t = 36'sh01FFD55B;
            6: t = 36'sh00FFFAAA;  7: t = 36'sh007FFF55;  8: t = 36'sh003FFFEA;
            9: t = 36'sh001FFFFD;  10: t = 36'sh000FFFFF; 11: t = 36'sh0007FFFF;
            12: t = 36'sh0003FFFF; 13: t = 36'sh0001FFFF; 14: t = 36'sh0000FFFF;
            15: t = 36'sh00007FFF; 16: t = 36'sh00003FFF; 17: t = 36'sh00001FFF;
            18: t = 36'sh00000FFF; 19: t = 36'sh000007FF; 20: t = 36'sh000003FF;
            21: t = 36'sh000001FF; 22: t = 36'sh000000FF; 23: t = 36'sh0000007F;
            24: t = 36'sh0000003F; 25: t = 36'sh0000001F; 26: t = 36'sh0000000F;
            27: t = 36'sh00000008; 28: t = 36'sh00000004; 29: t = 36'sh00000002;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Saturate a wide signed value to 32 bits; flag on clip
    function automatic logic [32:0] sat32(input logic signed [95:0] v);
        logic [32:0] r;
        if (v > 96'sd2147483647)       r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -96'sd2147483648) r = {1'b1, 32'h8000_0000};
        else                           r = {1'b0, v[31:0]};
        return r;
    endfunction

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [35:0] z;
        logic               neg;
    } t_cordic;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] v;
        logic signed [31:0] h;
        logic signed [31:0] w;
        logic signed [31:0] a;
        logic signed [31:0] yy;
        logic signed [31:0] dt;
        logic               ovf;
    } t_item;

endpackage

// ===== src/ctrv_sincos.sv =====
// ============================================================================
// ctrv_sincos
// Pipelined sine/cosine: modulo reduction, quadrant fold, one CORDIC step
// per stage. Results in Q6.30.
// ============================================================================
module ctrv_sincos
    import ctrv_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [33:0] i_ang,
    output logic signed [35:0] o_sin,
    output logic signed [35:0] o_cos
);

    logic signed [33:0] r_ang;
    logic signed [53:0] r_prod;
    logic signed [17:0] w_quo;
    logic signed [35:0] r_rem;
    logic signed [35:0] n_rem;
    logic signed [35:0] r_red;
    logic signed [35:0] n_red;
    t_cordic            r_st [CORDIC_STEPS+1];
    t_cordic            n_st0;

    // Reduction modulo 2*pi: reciprocal multiply, remainder, one correction
    assign w_quo = 18'(r_prod >>> RED_SHIFT);

    always_comb begin
        n_rem = 36'(r_ang) - 36'(w_quo) * TWO_PI_Q;
    end

    always_comb begin
        if (r_rem < 0)              n_red = r_rem + TWO_PI_Q;
        else if (r_rem >= TWO_PI_Q) n_red = r_rem - TWO_PI_Q;
        else                        n_red = r_rem;
    end

    always_comb begin
        logic signed [35:0] z;
        z = r_red <<< Q30_SHIFT;
        n_st0.neg = 1'b0;
        if (z > PI_Q30) z = z - TWO_PI_Q30;
        if (z > HALF_PI_Q30) begin
            z = z - PI_Q30; n_st0.neg = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30; n_st0.neg = 1'b1;
        end
        n_st0.x = CORDIC_GAIN;
        n_st0.y = '0;
        n_st0.z = z;
    end

    always_ff @(posedge i_clk) begin
        r_ang   <= i_ang;
        r_prod  <= 54'(i_ang) * 54'(TWO_PI_RECIP);
        r_rem   <= n_rem;
        r_red   <= n_red;
        r_st[0] <= n_st0;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        t_cordic n_nx;
        always_comb begin
            n_nx = r_st[g];
            if (r_st[g].z >= 0) begin
                n_nx.x = r_st[g].x - (r_st[g].y >>> g);
                n_nx.y = r_st[g].y + (r_st[g].x >>> g);
                n_nx.z = r_st[g].z - atan_q30(g);
            end else begin
                n_nx.x = r_st[g].x + (r_st[g].y >>> g);
                n_nx.y = r_st[g].y - (r_st[g].x >>> g);
                n_nx.z = r_st[g].z + atan_q30(g);
            end
        end
        always_ff @(posedge i_clk) begin
            r_st[g+1] <= n_nx;
        end
    end

    assign o_sin = r_st[CORDIC_STEPS].neg ? -r_st[CORDIC_STEPS].y : r_st[CORDIC_STEPS].y;
    assign o_cos = r_st[CORDIC_STEPS].neg ? -r_st[CORDIC_STEPS].x : r_st[CORDIC_STEPS].x;

endmodule

// ===== src/ctrv_div.sv =====
// ============================================================================
// ctrv_div
// Pipelined restoring divider, one quotient bit per stage, truncating toward
// zero. 64-bit magnitude dividend, 46-bit magnitude divisor.
// ============================================================================
module ctrv_div
    import ctrv_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [64:0] i_num,
    input  logic signed [46:0] i_den,
    output logic signed [65:0] o_quo
);

    localparam int QW = DIV_BITS;

    logic [QW-1:0] r_q   [QW+1];
    logic [46:0]   r_rem [QW+1];
    logic [45:0]   r_d   [QW+1];
    logic          r_neg [QW+1];

    always_ff @(posedge i_clk) begin
        r_q[0]   <= 64'(i_num[64] ? -i_num : i_num);
        r_rem[0] <= '0;
        r_d[0]   <= 46'(i_den[46] ? -i_den : i_den);
        r_neg[0] <= i_num[64] ^ i_den[46];
    end

    for (genvar g = 0; g < QW; g++) begin : g_bit
        logic [47:0] n_t;
        assign n_t = {r_rem[g], r_q[g][QW-1]} - {2'b0, r_d[g]};
        always_ff @(posedge i_clk) begin
            r_d[g+1]   <= r_d[g];
            r_neg[g+1] <= r_neg[g];
            if (!n_t[47]) begin
                r_rem[g+1] <= n_t[46:0];
                r_q[g+1]   <= {r_q[g][QW-2:0], 1'b1};
            end else begin
                r_rem[g+1] <= {r_rem[g][45:0], r_q[g][QW-1]};
                r_q[g+1]   <= {r_q[g][QW-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_neg[QW] ? -$signed({2'b0, r_q[QW]}) : $signed({2'b0, r_q[QW]});

endmodule

// ===== src/ctrv_process_model.sv =====
// ============================================================================
// ctrv_process_model
// CTRV sigma-point prediction with control vector and process noise.
// ============================================================================
// One transaction is taken in every cycle (busy is always low). Its result
// passes through the two parallel CORDIC pipelines (34 stages each, angle
// reduction included) and the two parallel 65-stage dividers and appears
// with o_valid. The receiver cannot stall; results are strobed for exactly
// one cycle each. Configuration must only change while no transaction is in
// flight.
module ctrv_process_model
    import ctrv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data,
    input  logic [47:0]        i_time_now,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_speed,
    input  logic signed [31:0] i_heading,
    input  logic signed [31:0] i_turn_rate,
    input  logic signed [31:0] i_accel_noise,
    input  logic signed [31:0] i_yaw_accel_noise,
    output logic               o_valid,
    output logic signed [31:0] o_next_pos_x,
    output logic signed [31:0] o_next_pos_y,
    output logic signed [31:0] o_next_speed,
    output logic signed [31:0] o_next_heading,
    output logic signed [31:0] o_next_turn_rate,
    output logic               o_overflow
);

    localparam int LSC = SC_LAT;
    localparam int LDV = DIV_LAT;
    // stage map: 0 dt, 1 dh, 2..LSC+1 cordic1 (h and h+dh run side by side
    // with matched latency), then products, divider, final sums, output
    localparam int T_END = LSC + LDV + 4;

    logic [47:0]        r_prev;
    logic signed [31:0] r_ctrl [5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            for (int k = 0; k < 5; k++) r_ctrl[k] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PREV_TIME:  r_prev    <= i_cfg_data;
                REG_CTRL_X:     r_ctrl[0] <= i_cfg_data[31:0];
                REG_CTRL_Y:     r_ctrl[1] <= i_cfg_data[31:0];
                REG_CTRL_SPEED: r_ctrl[2] <= i_cfg_data[31:0];
                REG_CTRL_HEAD:  r_ctrl[3] <= i_cfg_data[31:0];
                REG_CTRL_TURN:  r_ctrl[4] <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid line
    logic [T_END:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[T_END-1:0], start};
    end

    // stage 0: dt
    t_item r_s0;
    always_ff @(posedge i_clk) begin
        logic [32:0] d;
        d = sat32(96'($signed({1'b0, i_time_now}) - $signed({1'b0, r_prev})));
        r_s0.px <= i_pos_x; r_s0.py <= i_pos_y; r_s0.v <= i_speed;
        r_s0.h  <= i_heading; r_s0.w <= i_turn_rate;
        r_s0.a  <= i_accel_noise; r_s0.yy <= i_yaw_accel_noise;
        r_s0.dt <= d[31:0]; r_s0.ovf <= d[32];
    end

    // stage 1: dh = w*dt, half_dt2, dt*a, dt*yy
    t_item              r_s1;
    logic signed [31:0] r_dh1, r_hd2, r_dta, r_dty;
    always_ff @(posedge i_clk) begin
        t_item       it;
        logic [32:0] p0, p1, p2, p3;
        p0 = sat32(96'((64'(r_s0.w) * 64'(r_s0.dt)) >>> FRAC_BITS));
        p1 = sat32(96'((64'(r_s0.dt) * 64'(r_s0.dt)) >>> (FRAC_BITS + 1)));
        p2 = sat32(96'((64'(r_s0.dt) * 64'(r_s0.a)) >>> FRAC_BITS));
        p3 = sat32(96'((64'(r_s0.dt) * 64'(r_s0.yy)) >>> FRAC_BITS));
        it = r_s0;
        it.ovf = r_s0.ovf | p1[32] | p2[32] | p3[32]
               | ((r_s0.w != 0) & p0[32]);
        r_s1 <= it;
        r_dh1 <= (r_s0.w != 0) ? p0[31:0] : 32'sd0;
        r_hd2 <= p1[31:0]; r_dta <= p2[31:0]; r_dty <= p3[31:0];
    end

    logic signed [35:0] w_s0, w_c0, w_s1, w_c1;
    ctrv_sincos u_sc0 (.i_clk(i_clk), .i_ang(34'(r_s1.h)),
                       .o_sin(w_s0), .o_cos(w_c0));
    ctrv_sincos u_sc1 (.i_clk(i_clk), .i_ang(34'(r_s1.h) + 34'(r_dh1)),
                       .o_sin(w_s1), .o_cos(w_c1));

    // delay line for item data over the CORDIC
    t_item              r_d1 [LSC];
    logic signed [31:0] r_dd [LSC][4];
    always_ff @(posedge i_clk) begin
        r_d1[0] <= r_s1;
        r_dd[0][0] <= r_dh1; r_dd[0][1] <= r_hd2;
        r_dd[0][2] <= r_dta; r_dd[0][3] <= r_dty;
        for (int k = 1; k < LSC; k++) begin
            r_d1[k] <= r_d1[k-1]; r_dd[k] <= r_dd[k-1];
        end
    end
    // w_s0 etc align with r_d1[LSC-1]

    // stage A: first products and arc numerators
    t_item              r_a;
    logic signed [31:0] r_adh, r_ahd2, r_adta, r_adty;
    logic signed [31:0] r_vc, r_vs, r_hc, r_hs;
    logic signed [64:0] r_nx, r_ny;
    logic signed [46:0] r_den;
    always_ff @(posedge i_clk) begin
        t_item it;
        logic [32:0] q0, q1, q2, q3;
        it = r_d1[LSC-1];
        q0 = sat32(96'((68'(it.v) * 68'(w_c0)) >>> 30));
        q1 = sat32(96'((68'(it.v) * 68'(w_s0)) >>> 30));
        q2 = sat32(96'((68'(r_dd[LSC-1][1]) * 68'(w_c0)) >>> 30));
        q3 = sat32(96'((68'(r_dd[LSC-1][1]) * 68'(w_s0)) >>> 30));
        it.ovf = it.ovf | q2[32] | q3[32] | ((it.w == 0) & (q0[32] | q1[32]));
        r_a <= it;
        r_vc <= q0[31:0]; r_vs <= q1[31:0]; r_hc <= q2[31:0]; r_hs <= q3[31:0];
        r_adh <= r_dd[LSC-1][0]; r_ahd2 <= r_dd[LSC-1][1];
        r_adta <= r_dd[LSC-1][2]; r_adty <= r_dd[LSC-1][3];
        r_nx <= 65'(it.v) * 65'(w_s1 - w_s0);
        r_ny <= 65'(it.v) * 65'(w_c0 - w_c1);
        r_den <= (it.w == 0) ? 47'sd1 : 47'(it.w) <<< Q30_SHIFT;
    end

    // stage B: second products
    t_item              r_b;
    logic signed [31:0] r_bdh, r_bdx, r_bdy, r_bnx, r_bny, r_bdta, r_bdty, r_byh;
    always_ff @(posedge i_clk) begin
        t_item       it;
        logic [32:0] e0, e1, e2, e3, e4;
        e0 = sat32(96'((64'(r_vc) * 64'(r_a.dt)) >>> FRAC_BITS));
        e1 = sat32(96'((64'(r_vs) * 64'(r_a.dt)) >>> FRAC_BITS));
        e2 = sat32(96'((64'(r_hc) * 64'(r_a.a)) >>> FRAC_BITS));
        e3 = sat32(96'((64'(r_hs) * 64'(r_a.a)) >>> FRAC_BITS));
        e4 = sat32(96'((64'(r_ahd2) * 64'(r_a.yy)) >>> FRAC_BITS));
        it = r_a;
        it.ovf = r_a.ovf | e2[32] | e3[32] | e4[32]
               | ((r_a.w == 0) & (e0[32] | e1[32]));
        r_b <= it;
        r_bdx <= e0[31:0]; r_bdy <= e1[31:0];
        r_bnx <= e2[31:0]; r_bny <= e3[31:0]; r_byh <= e4[31:0];
        r_bdh <= r_adh; r_bdta <= r_adta; r_bdty <= r_adty;
    end

    logic signed [65:0] w_qx, w_qy;
    ctrv_div u_dvx (.i_clk(i_clk), .i_num(r_nx), .i_den(r_den), .o_quo(w_qx));
    ctrv_div u_dvy (.i_clk(i_clk), .i_num(r_ny), .i_den(r_den), .o_quo(w_qy));

    // align stage B data with divider output (divider starts from stage A)
    t_item              r_e [LDV-1];
    logic signed [31:0] r_ed [LDV-1][6];
    always_ff @(posedge i_clk) begin
        r_e[0] <= r_b;
        r_ed[0][0] <= r_bdh; r_ed[0][1] <= r_bdx; r_ed[0][2] <= r_bdy;
        r_ed[0][3] <= r_bnx; r_ed[0][4] <= r_bny; r_ed[0][5] <= r_byh;
        for (int k = 1; k < LDV-1; k++) begin
            r_e[k] <= r_e[k-1]; r_ed[k] <= r_ed[k-1];
        end
    end

    // final sums
    t_item              r_f;
    logic signed [31:0] r_fdx, r_fdy;
    logic signed [31:0] r_fd [6];
    logic signed [31:0] r_fdta, r_fdty;
    logic signed [31:0] r_dta_l [LDV-1];
    logic signed [31:0] r_dty_l [LDV-1];
    always_ff @(posedge i_clk) begin
        r_dta_l[0] <= r_bdta; r_dty_l[0] <= r_bdty;
        for (int k = 1; k < LDV-1; k++) begin
            r_dta_l[k] <= r_dta_l[k-1]; r_dty_l[k] <= r_dty_l[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        t_item it;
        logic [32:0] sx, sy;
        it = r_e[LDV-2];
        sx = sat32(96'(w_qx));
        sy = sat32(96'(w_qy));
        if (it.w == 0) begin
            r_fdx <= r_ed[LDV-2][1]; r_fdy <= r_ed[LDV-2][2];
        end else begin
            r_fdx <= sx[31:0]; r_fdy <= sy[31:0];
            it.ovf = it.ovf | sx[32] | sy[32];
        end
        r_f <= it;
        r_fd <= r_ed[LDV-2];
        r_fdta <= r_dta_l[LDV-2]; r_fdty <= r_dty_l[LDV-2];
    end

    always_ff @(posedge i_clk) begin
        logic [32:0] o0, o1, o2, o3, o4;
        o0 = sat32(96'(r_f.px) + 96'(r_fdx) + 96'(r_ctrl[0]) + 96'(r_fd[3]));
        o1 = sat32(96'(r_f.py) + 96'(r_fdy) + 96'(r_ctrl[1]) + 96'(r_fd[4]));
        o2 = sat32(96'(r_f.v) + 96'(r_ctrl[2]) + 96'(r_fdta));
        o3 = sat32(96'(r_f.h) + 96'(r_fd[0]) + 96'(r_ctrl[3]) + 96'(r_fd[5]));
        o4 = sat32(96'(r_f.w) + 96'(r_ctrl[4]) + 96'(r_fdty));
        o_next_pos_x <= o0[31:0]; o_next_pos_y <= o1[31:0];
        o_next_speed <= o2[31:0]; o_next_heading <= o3[31:0];
        o_next_turn_rate <= o4[31:0];
        o_overflow <= r_f.ovf | o0[32] | o1[32] | o2[32] | o3[32] | o4[32];
    end

    assign o_valid = r_vld[T_END];

endmodule

// ===== test/tb_ctrv_process_model.sv =====
// ============================================================================
// tb_ctrv_process_model
// Self-checking bench for the CTRV sigma-point predictor: directed rows and
// random sigma points are checked against a bit-accurate fixed-point model,
// across several control-vector and previous-time settings.
// ============================================================================
module tb_ctrv_process_model;
    timeunit 1ns;
    timeprecision 1ps;
    import ctrv_pkg::*;

    localparam int  DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [47:0]        i_cfg_data = '0;
    logic [47:0]        i_time_now = '0;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_speed = '0, i_heading = '0;
    logic signed [31:0] i_turn_rate = '0, i_accel_noise = '0, i_yaw_accel_noise = '0;
    logic               o_valid;
    logic signed [31:0] o_next_pos_x, o_next_pos_y, o_next_speed;
    logic signed [31:0] o_next_heading, o_next_turn_rate;
    logic               o_overflow;

    ctrv_process_model dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct {
        logic [47:0]        t;
        logic signed [31:0] px, py, v, h, w, a, yy;
    } t_point;

    typedef struct {
        logic signed [31:0] px, py, v, h, w;
        logic               ovf;
    } t_next_state;

    typedef struct {
        t_point      pt;
        bit          typed;
        t_next_state want;
    } t_row;

    logic [47:0]    prev_time;
    longint         ctrl_vec[5];
    t_next_state    expected_q[$];
    int             errors = 0;
    longint         cycles = 0;
    int             n_checked = 0, n_turning = 0, n_ovf = 0;
    bit             sat_flag;

    function automatic longint floor_shift(longint v, int s);
        return v >= 0 ? (v >>> s) : -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) begin
            sat_flag = 1; return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat_flag = 1; return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint fxmul(longint a, longint b, int s);
        return clip32(floor_shift(a * b, s));
    endfunction

    function automatic longint atan_step(int i);
        longint tab[30] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
        return tab[i];
    endfunction

    task automatic rotate_angle(input longint ang, output longint s, output longint c);
        longint one = 64'sd1 <<< Q30_SHIFT;
        longint two_pi = 64'sd6746518852;
        longint pi = 64'sd3373259426;
        longint half_pi = 64'sd1686629713;
        longint tp = (two_pi + (one >>> 1)) >>> Q30_SHIFT;
        longint r, x, y, z, nx;
        bit     flip;
        r = ang % tp;
        if (r < 0) r += tp;
        z = r * one;
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z > pi) z -= two_pi;
        if (z > half_pi) begin
            z -= pi; flip = 1;
        end else if (z < -half_pi) begin
            z += pi; flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= atan_step(i);
            end else begin
                nx = x + floor_shift(y, i); y = y - floor_shift(x, i); z += atan_step(i);
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    task automatic predict_motion(input t_point p, output t_next_state r);
        longint px = p.px, py = p.py, v = p.v, h = p.h, w = p.w, a = p.a, yy = p.yy;
        longint dt, s0, c0, s1, c1, dx, dy, dh, hdt2, den;
        longint res[5];
        sat_flag = 0;
        dt = clip32(longint'({16'd0, p.t}) - longint'({16'd0, prev_time}));
        rotate_angle(h, s0, c0);
        if (w == 0) begin
            dx = fxmul(fxmul(v, c0, 30), dt, FRAC_BITS);
            dy = fxmul(fxmul(v, s0, 30), dt, FRAC_BITS);
            dh = 0;
        end else begin
            den = w * (64'sd1 <<< Q30_SHIFT);
            dh = fxmul(w, dt, FRAC_BITS);
            rotate_angle(h + dh, s1, c1);
            dx = clip32((v * (s1 - s0)) / den);
            dy = clip32((v * (c0 - c1)) / den);
        end
        hdt2 = fxmul(dt, dt, FRAC_BITS + 1);
        res[0] = px + dx + ctrl_vec[0] + fxmul(fxmul(hdt2, c0, 30), a, FRAC_BITS);
        res[1] = py + dy + ctrl_vec[1] + fxmul(fxmul(hdt2, s0, 30), a, FRAC_BITS);
        res[2] = v + ctrl_vec[2] + fxmul(dt, a, FRAC_BITS);
        res[3] = h + dh + ctrl_vec[3] + fxmul(hdt2, yy, FRAC_BITS);
        res[4] = w + ctrl_vec[4] + fxmul(dt, yy, FRAC_BITS);
        for (int i = 0; i < 5; i++) res[i] = clip32(res[i]);
        r.px = res[0]; r.py = res[1]; r.v = res[2]; r.h = res[3]; r.w = res[4];
        r.ovf = sat_flag;
    endtask

    // Result monitor
    always @(posedge i_clk) begin
        t_next_state e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = expected_q.pop_front();
                n_checked++;
                if (o_overflow) n_ovf++;
                if (o_next_pos_x !== e.px) begin
                    $error("next_pos_x exp %0d got %0d", e.px, o_next_pos_x); errors++;
                end
                if (o_next_pos_y !== e.py) begin
                    $error("next_pos_y exp %0d got %0d", e.py, o_next_pos_y); errors++;
                end
                if (o_next_speed !== e.v) begin
                    $error("next_speed exp %0d got %0d", e.v, o_next_speed); errors++;
                end
                if (o_next_heading !== e.h) begin
                    $error("next_heading exp %0d got %0d", e.h, o_next_heading); errors++;
                end
                if (o_next_turn_rate !== e.w) begin
                    $error("next_turn_rate exp %0d got %0d", e.w, o_next_turn_rate);
                    errors++;
                end
                if (o_overflow !== e.ovf) begin
                    $error("overflow exp %0b got %0b", e.ovf, o_overflow); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [47:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_PREV_TIME) prev_time = val;
        else ctrl_vec[int'(idx) - 1] = longint'(signed'(val[31:0]));
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Drives at the current negedge; start stays high if the next call follows
    task automatic send_point(input t_point p, input bit typed, input t_next_state want);
        t_next_state e;
        i_time_now <= p.t;
        i_pos_x <= p.px; i_pos_y <= p.py; i_speed <= p.v; i_heading <= p.h;
        i_turn_rate <= p.w; i_accel_noise <= p.a; i_yaw_accel_noise <= p.yy;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (typed) e = want;
        else predict_motion(p, e);
        if (p.w != 0) n_turning++;
        expected_q.push_back(e);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            3: return {{14{1'b0}}, 18'($urandom)} - 32'h0002_0000;
            default: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
        endcase
    endfunction

    function automatic t_point rand_point();
        t_point p;
        p.t = ($urandom_range(0, 15) == 0) ? {$urandom, 16'($urandom)}
                                          : prev_time + 48'($urandom_range(0, 20'hFFFFF))
                                            - 48'h4_0000;
        p.px = rand_field(); p.py = rand_field(); p.v = rand_field();
        p.h = rand_field(); p.yy = rand_field(); p.a = rand_field();
        p.w = ($urandom_range(0, 3) == 0) ? 32'sd0 : rand_field();
        return p;
    endfunction

    initial begin
        t_row        rows[$];
        t_row        rw;
        t_point      p;
        t_next_state none;
        int          burst;
        for (int i = 0; i < 5; i++) ctrl_vec[i] = 0;
        prev_time = '0;
        none = '{default: '0};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All zero after reset: result is all zero
        rw.pt = '{default: '0}; rw.typed = 1; rw.want = none; rows.push_back(rw);
        // dt zero, straight line: state passes through
        rw.pt = '{t: 0, px: 32'sd12345, py: -32'sd777, v: 32'sd65536, h: 32'sd0,
                  w: 32'sd0, a: 32'sd0, yy: 32'sd0};
        rw.want = '{px: 32'sd12345, py: -32'sd777, v: 32'sd65536, h: 0, w: 0, ovf: 0};
        rows.push_back(rw);
        // Extremes, dt zero, no noise: nothing saturates
        rw.pt = '{t: 0, px: 32'h7FFF_FFFF, py: 32'h8000_0000, v: 32'h7FFF_FFFF,
                  h: 32'h8000_0000, w: 32'sd0, a: 32'sd0, yy: 32'sd0};
        rw.want = '{px: 32'h7FFF_FFFF, py: 32'h8000_0000, v: 32'h7FFF_FFFF,
                    h: 32'h8000_0000, w: 0, ovf: 0};
        rows.push_back(rw);
        // Large dt saturates and flags
        rw.typed = 0;
        rw.pt = '{t: 48'hFFFF_FFFF_FFFF, px: 0, py: 0, v: 32'sd65536, h: 0,
                  w: 0, a: 0, yy: 0};
        rows.push_back(rw);
        rw.pt = '{t: 48'h0000_8000_0000, px: 0, py: 0, v: 32'sd65536, h: 32'sd102944,
                  w: 32'sd6554, a: 32'sd1000, yy: -32'sd1000};
        rows.push_back(rw);
        // Turning, small dt; negative and extreme yaw rate; heading near +-pi/2 and pi
        rw.pt = '{t: 48'h1_0000, px: 0, py: 0, v: 32'sd655360, h: 32'sd102944,
                  w: 32'sd65536, a: 32'sd65536, yy: 32'sd65536};
        rows.push_back(rw);
        rw.pt = '{t: 48'h8000, px: -5, py: 5, v: -32'sd655360, h: 32'sd205887,
                  w: -32'sd1, a: -32'sd65536, yy: 32'sd3};
        rows.push_back(rw);
        rw.pt = '{t: 48'h1, px: 0, py: 0, v: 32'h7FFF_FFFF, h: -32'sd102944,
                  w: 32'h8000_0000, a: 32'h7FFF_FFFF, yy: 32'h8000_0000};
        rows.push_back(rw);
        rw.pt = '{t: 48'h3_0000, px: 32'h7FFF_FFFF, py: 32'h7FFF_FFFF,
                  v: 32'h8000_0000, h: 32'h7FFF_FFFF, w: 32'h7FFF_FFFF,
                  a: 32'h8000_0000, yy: 32'h7FFF_FFFF};
        rows.push_back(rw);
        foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].want);
        start <= 1'b0;
        wait_drained();

        // Negative dt and nonzero controls
        write_reg(REG_PREV_TIME, 48'h0005_0000);
        write_reg(REG_CTRL_X, 48'h7FFF_FFFF);
        write_reg(REG_CTRL_Y, 48'h8000_0000);
        write_reg(REG_CTRL_SPEED, 48'hFFFF_0000);
        write_reg(REG_CTRL_HEAD, 48'h0001_921F);
        write_reg(REG_CTRL_TURN, 48'h0000_0001);
        rw.pt = '{t: 48'h2_0000, px: 32'sd100, py: -32'sd100, v: 32'sd131072,
                  h: 32'sd1000, w: 32'sd0, a: 32'sd65536, yy: 32'sd65536};
        send_point(rw.pt, 0, none);
        rw.pt.w = 32'sd32768;
        send_point(rw.pt, 0, none);
        start <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 3) begin
                write_reg(REG_PREV_TIME, 48'hFFFF_FFFF_FFFF);
                for (int r = 1; r <= 5; r++)
                    write_reg(t_reg_idx'(r), 48'h8000_0000);
            end else begin
                write_reg(REG_PREV_TIME, {$urandom, 16'($urandom)} >> (phase * 16));
                for (int r = 1; r <= 5; r++)
                    write_reg(t_reg_idx'(r), phase == 0 ? 48'h0 : 48'($urandom));
            end
            for (int n = 0; n < 200; ) begin
                burst = $urandom_range(1, 40);
                for (int b = 0; b < burst && n < 200; b++, n++) begin
                    p = rand_point();
                    send_point(p, 0, none);
                end
                if ($urandom_range(0, 2) != 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge i_clk);
                end
            end
            start <= 1'b0;
            wait_drained();
        end

        $display("Checked %0d predictions (%0d turning, %0d with overflow) over 6 settings.",
                 n_checked, n_turning, n_ovf);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
